// ----- src/dbgtok_pkg.sv -----
// Shared types, constants and helper functions for the debugger reply tokenizer.
package dbgtok_pkg;

    localparam int HOLD_DEPTH = 16;
    localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);

    // Lexer modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_PROMPT = 2'd1;
    localparam logic [1:0] MODE_STRING = 2'd2;
    localparam logic [1:0] MODE_WORD   = 2'd3;

    // Result events.
    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_CHAR   = 2'd1;
    localparam logic [1:0] EV_RETYPE = 2'd2;
    localparam logic [1:0] EV_LINE   = 2'd3;

    // Token kinds.
    localparam logic [3:0] KIND_STRING = 4'd0;
    localparam logic [3:0] KIND_PROMPT = 4'd1;
    localparam logic [3:0] KIND_WORD   = 4'd2;
    localparam logic [3:0] KIND_NONE   = 4'd15;

    // Controller states, in the order in which the results of one byte leave.
    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_FLUSH  = 3'd2;
    localparam logic [2:0] ST_CHAR   = 3'd3;
    localparam logic [2:0] ST_RETYPE = 3'd4;
    localparam logic [2:0] ST_LINE   = 3'd5;

    // Characters with a special meaning.
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;

    // Which results one accepted byte produces.
    typedef struct packed {
        logic       start;
        logic [3:0] kind;
        logic       flush;
        logic       chr;
        logic       chr_hold;
        logic       retype;
        logic       line;
    } plan_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic [2:0] phase;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        plan_t plan_in;
        plan_t plan;
        logic  hold_last;
        logic  hold_empty;
        logic  out_free;
    } dp_status_t;

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            8'h3D:   k = 4'd3;
            8'h7B:   k = 4'd4;
            8'h7D:   k = 4'd5;
            8'h5B:   k = 4'd6;
            8'h5D:   k = 4'd7;
            8'h2C:   k = 4'd8;
            8'h5E:   k = 4'd9;
            8'h2B:   k = 4'd10;
            8'h7E:   k = 4'd11;
            8'h40:   k = 4'd12;
            8'h26:   k = 4'd13;
            8'h2A:   k = 4'd14;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    function automatic logic [7:0] prompt_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h28;
            3'd1:    ch = 8'h67;
            3'd2:    ch = 8'h64;
            3'd3:    ch = 8'h62;
            3'd4:    ch = 8'h29;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // First phase after the given one that the plan asks for; ST_WAIT when none is left.
    function automatic logic [2:0] next_phase(input plan_t p, input logic [2:0] after);
        logic [2:0] nxt;
        priority if (after < ST_START && p.start)
            nxt = ST_START;
        else if (after < ST_FLUSH && p.flush)
            nxt = ST_FLUSH;
        else if (after < ST_CHAR && p.chr)
            nxt = ST_CHAR;
        else if (after < ST_RETYPE && p.retype)
            nxt = ST_RETYPE;
        else if (after < ST_LINE && p.line)
            nxt = ST_LINE;
        else
            nxt = ST_WAIT;
        return nxt;
    endfunction

endpackage

// ----- src/dbgtok_ctrl.sv -----
// Controller: walks through the results planned for one accepted byte.
module dbgtok_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dbgtok_pkg::dp_status_t status,
    output dbgtok_pkg::dp_cmd_t    cmd
);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] after;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = state_reg;
        after      = dbgtok_pkg::next_phase(status.plan, state_reg);
        s_tready   = (state_reg == dbgtok_pkg::ST_WAIT);
        unique case (state_reg)
            dbgtok_pkg::ST_WAIT:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dbgtok_pkg::next_phase(status.plan_in, dbgtok_pkg::ST_WAIT);
                end
            end
            dbgtok_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = status.hold_last && (after == dbgtok_pkg::ST_WAIT);
                    if (status.hold_last)
                        state_next = after;
                end
            end
            dbgtok_pkg::ST_START, dbgtok_pkg::ST_CHAR,
            dbgtok_pkg::ST_RETYPE, dbgtok_pkg::ST_LINE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = (after == dbgtok_pkg::ST_WAIT);
                    state_next = after;
                end
            end
            default:
                state_next = dbgtok_pkg::ST_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dbgtok_pkg::ST_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/dbgtok_dp.sv -----
// Datapath: lexer state, whitespace hold buffer and the output register.
module dbgtok_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  dbgtok_pkg::dp_cmd_t    cmd,
    output dbgtok_pkg::dp_status_t status,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic [5:0]             m_tuser,
    output logic                   m_tlast
);

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [2:0] match_reg;
    logic [2:0] match_next;
    logic       esc_reg;
    logic       esc_next;
    logic       wht_reg;
    logic       wht_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    dbgtok_pkg::plan_t plan_reg;
    dbgtok_pkg::plan_t plan_in;

    logic [dbgtok_pkg::HOLD_CW-1:0] count_reg;
    logic [dbgtok_pkg::HOLD_AW-1:0] head_reg;
    logic [7:0] hold_reg [dbgtok_pkg::HOLD_DEPTH];
    logic [dbgtok_pkg::HOLD_CW:0]   tail_sum;
    logic [dbgtok_pkg::HOLD_AW-1:0] tail;
    logic [dbgtok_pkg::HOLD_AW:0]   head_inc;
    logic [dbgtok_pkg::HOLD_AW-1:0] head_adv;
    logic [7:0] hold_rd;
    logic       push;
    logic       clr;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [1:0] out_event_reg;
    logic [3:0] out_kind_reg;
    logic       out_last_reg;
    logic [7:0] ch_sel;
    logic [1:0] ev_sel;
    logic [3:0] kind_sel;

    logic [3:0] kind_p;
    logic       ws;
    logic       delim;
    logic       as_idle;
    logic       mismatch;

    assign hold_rd  = hold_reg[head_reg];
    assign tail_sum = {1'b0, dbgtok_pkg::HOLD_CW'(head_reg)} + {1'b0, count_reg};
    assign head_inc = {1'b0, head_reg} + 1'b1;
    assign head_adv = (head_inc == dbgtok_pkg::HOLD_DEPTH) ? '0 : head_inc[dbgtok_pkg::HOLD_AW-1:0];

    always_comb
    begin
        if (tail_sum >= dbgtok_pkg::HOLD_DEPTH)
            tail = dbgtok_pkg::HOLD_AW'(tail_sum - dbgtok_pkg::HOLD_DEPTH);
        else
            tail = tail_sum[dbgtok_pkg::HOLD_AW-1:0];
    end

    // Decide, from the incoming byte and the lexer state, which results it will produce.
    always_comb
    begin
        plan_in    = '0;
        mode_next  = mode_reg;
        match_next = match_reg;
        esc_next   = esc_reg;
        wht_next   = wht_reg;
        byte_next  = s_tdata;
        push       = 1'b0;
        clr        = 1'b0;
        kind_p     = dbgtok_pkg::punct_kind(s_tdata);
        ws         = dbgtok_pkg::is_ws(s_tdata);
        delim      = s_tdata == dbgtok_pkg::CH_EQ || s_tdata == dbgtok_pkg::CH_COMMA ||
                     s_tdata == dbgtok_pkg::CH_LBRACE || s_tdata == dbgtok_pkg::CH_RBRACE;
        as_idle    = (mode_reg == dbgtok_pkg::MODE_IDLE) ||
                     (mode_reg == dbgtok_pkg::MODE_WORD && delim);
        mismatch   = (match_reg >= 3'd5) || (s_tdata != dbgtok_pkg::prompt_char(match_reg));

        if (as_idle)
        begin
            // A delimiter ends the word and is then lexed as a fresh token.
            if (mode_reg == dbgtok_pkg::MODE_WORD)
            begin
                wht_next  = 1'b0;
                clr       = 1'b1;
                mode_next = dbgtok_pkg::MODE_IDLE;
            end
            priority if (s_tdata == dbgtok_pkg::CH_QUOTE)
            begin
                plan_in.start = 1'b1;
                plan_in.kind  = dbgtok_pkg::KIND_STRING;
                mode_next     = dbgtok_pkg::MODE_STRING;
                esc_next      = 1'b0;
            end
            else if (s_tdata == dbgtok_pkg::CH_LPAREN)
            begin
                plan_in.start = 1'b1;
                plan_in.kind  = dbgtok_pkg::KIND_PROMPT;
                plan_in.chr   = 1'b1;
                mode_next     = dbgtok_pkg::MODE_PROMPT;
                match_next    = 3'd1;
            end
            else if (kind_p != dbgtok_pkg::KIND_NONE)
            begin
                plan_in.start = 1'b1;
                plan_in.kind  = kind_p;
                plan_in.chr   = 1'b1;
            end
            else if (s_tdata != dbgtok_pkg::CH_SPACE)
            begin
                // Leading whitespace other than a space opens a word but is not part of it.
                plan_in.start = 1'b1;
                plan_in.kind  = dbgtok_pkg::KIND_WORD;
                plan_in.chr   = !ws;
                mode_next     = dbgtok_pkg::MODE_WORD;
                wht_next      = !ws;
            end
            else
                plan_in.start = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                dbgtok_pkg::MODE_PROMPT:
                begin
                    plan_in.chr = 1'b1;
                    if (mismatch)
                    begin
                        plan_in.retype = 1'b1;
                        mode_next      = dbgtok_pkg::MODE_IDLE;
                        match_next     = 3'd0;
                    end
                    else if (match_reg == 3'd4)
                    begin
                        mode_next  = dbgtok_pkg::MODE_IDLE;
                        match_next = 3'd0;
                    end
                    else
                        match_next = match_reg + 3'd1;
                end
                dbgtok_pkg::MODE_STRING:
                begin
                    priority if (esc_reg)
                    begin
                        plan_in.chr = 1'b1;
                        esc_next    = 1'b0;
                        if (s_tdata == dbgtok_pkg::CH_LOWER_N)
                            byte_next = dbgtok_pkg::CH_NEWLINE;
                    end
                    else if (s_tdata == dbgtok_pkg::CH_BSLASH)
                        esc_next = 1'b1;
                    else if (s_tdata == dbgtok_pkg::CH_QUOTE)
                        mode_next = dbgtok_pkg::MODE_IDLE;
                    else
                        plan_in.chr = 1'b1;
                end
                default:
                begin
                    if (ws)
                    begin
                        if (wht_reg)
                        begin
                            if (count_reg < dbgtok_pkg::HOLD_DEPTH)
                                push = 1'b1;
                            else
                            begin
                                // Hold full: the oldest byte leaves, the new one takes its slot.
                                plan_in.chr      = 1'b1;
                                plan_in.chr_hold = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        plan_in.flush = (count_reg != '0);
                        plan_in.chr   = 1'b1;
                        wht_next      = 1'b1;
                    end
                end
            endcase
        end

        plan_in.line = s_tlast;
        if (s_tlast)
        begin
            mode_next  = dbgtok_pkg::MODE_IDLE;
            match_next = 3'd0;
            esc_next   = 1'b0;
            wht_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dbgtok_pkg::MODE_IDLE;
            match_reg <= 3'd0;
            esc_reg   <= 1'b0;
            wht_reg   <= 1'b0;
            plan_reg  <= '0;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else if (cmd.load)
        begin
            mode_reg  <= mode_next;
            match_reg <= match_next;
            esc_reg   <= esc_next;
            wht_reg   <= wht_next;
            plan_reg  <= plan_in;
            if (clr)
            begin
                count_reg <= '0;
                head_reg  <= '0;
            end
            else if (push)
                count_reg <= count_reg + 1'b1;
        end
        else if (cmd.emit)
        begin
            if (cmd.phase == dbgtok_pkg::ST_FLUSH)
            begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_adv;
            end
            else if (cmd.phase == dbgtok_pkg::ST_CHAR && plan_reg.chr_hold)
                head_reg <= head_adv;
            else if (cmd.phase == dbgtok_pkg::ST_LINE)
            begin
                count_reg <= '0;
                head_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= byte_next;
        if (cmd.load && push)
            hold_reg[tail] <= s_tdata;
        else if (cmd.emit && cmd.phase == dbgtok_pkg::ST_CHAR && plan_reg.chr_hold)
            hold_reg[head_reg] <= byte_reg;
    end

    always_comb
    begin
        ev_sel   = dbgtok_pkg::EV_CHAR;
        kind_sel = 4'd0;
        ch_sel   = 8'h00;
        unique case (cmd.phase)
            dbgtok_pkg::ST_START:
            begin
                ev_sel   = dbgtok_pkg::EV_START;
                kind_sel = plan_reg.kind;
            end
            dbgtok_pkg::ST_FLUSH:
                ch_sel = hold_rd;
            dbgtok_pkg::ST_CHAR:
                ch_sel = plan_reg.chr_hold ? hold_rd : byte_reg;
            dbgtok_pkg::ST_RETYPE:
            begin
                ev_sel   = dbgtok_pkg::EV_RETYPE;
                kind_sel = dbgtok_pkg::KIND_WORD;
            end
            dbgtok_pkg::ST_LINE:
                ev_sel = dbgtok_pkg::EV_LINE;
            default:
                ev_sel = dbgtok_pkg::EV_CHAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg  <= ch_sel;
            out_event_reg <= ev_sel;
            out_kind_reg  <= kind_sel;
            out_last_reg  <= cmd.last;
        end
    end

    assign status.plan_in    = plan_in;
    assign status.plan       = plan_reg;
    assign status.hold_last  = (count_reg == dbgtok_pkg::HOLD_CW'(1));
    assign status.hold_empty = (count_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_kind_reg, out_event_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- src/debugger_reply_tokenizer_core.sv -----
// Top level of the debugger reply tokenizer: controller, datapath and checks.
//
//  Channel | Dir | Signals                        | Contents
//  --------+-----+--------------------------------+------------------------------------------
//  s_*     | in  | tvalid tready tdata[7:0] tlast | reply byte; tlast marks the final byte
//  m_*     | out | tvalid tready tdata[7:0]       | token event; tuser event, kind; tlast
//          |     | tuser[5:0] tlast               | marks the final result of one byte
//
// A byte is accepted while the block waits; it then occupies the block until it has
// issued all the results it produces (0 to HOLD_DEPTH + 2) through the single output
// register. Held whitespace is released byte by byte, read from the hold buffer.
// A byte that produces no result frees the input again in the next cycle.
// After reset the lexer is idle with an empty hold buffer; no clearing pass is needed.
// A stalled output holds the sequencer, and with it the input.
module debugger_reply_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic [5:0] m_tuser,   // [1:0] event_res, [5:2] token_kind
    output logic       m_tlast
);

    dbgtok_pkg::dp_cmd_t    cmd;
    dbgtok_pkg::dp_status_t status;

    dbgtok_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dbgtok_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // A line-end result always closes the results of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == dbgtok_pkg::EV_LINE |-> m_tlast)
        else $error("line-end transaction without tlast");

    // Only character results carry a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != dbgtok_pkg::EV_CHAR |-> m_tdata == 8'h00)
        else $error("non-character transaction carries data");

    // Sending the line end empties the hold buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.phase == dbgtok_pkg::ST_LINE |=> status.hold_empty)
        else $error("hold buffer not empty after line end");
`endif

endmodule

// ----- verif/token_stream_checker.sv -----
// Checker that lexes every accepted reply byte itself and compares the token events that leave.
module token_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] char_out
    input  logic [5:0] m_tuser,   // [1:0] event_res, [5:2] token_kind
    input  logic       m_tlast,
    output int         fault_count,
    output int         events_due
);

    localparam logic [3:0]  NO_KIND     = 4'd0;
    localparam logic [7:0]  NO_CHAR     = 8'h00;
    localparam logic [39:0] PROMPT_TEXT = "(gdb)";
    localparam logic [95:0] PUNCT_CHARS = "={}[],^+~@&*";

    typedef struct packed {
        logic [1:0] ev;
        logic [3:0] kind;
        logic [7:0] ch;
        logic       last;
    } token_event_t;

    token_event_t due_q[$];
    token_event_t byte_events[$];
    token_event_t want;
    int           faults;

    // Lexer state of the prediction.
    logic [1:0] lex_mode_r;
    logic [2:0] prompt_seen;
    logic       in_escape;
    logic [7:0] held_ws [dbgtok_pkg::HOLD_DEPTH];
    int         held_count;
    logic       word_text;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h85) || (c == 8'hA0) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [3:0] punct_code(input logic [7:0] c);
        logic [3:0] code;
        code = dbgtok_pkg::KIND_NONE;
        for (int i = 0; i < 12; i++)
        begin
            if (PUNCT_CHARS[95 - 8 * i -: 8] == c)
                code = 4'(i + 3);
        end
        return code;
    endfunction

    task automatic note(input logic [1:0] ev, input logic [3:0] kind, input logic [7:0] ch);
        token_event_t e;
        e.ev   = ev;
        e.kind = kind;
        e.ch   = ch;
        e.last = 1'b0;
        byte_events.insert(byte_events.size(), e);
    endtask

    task automatic clear_lexer();
        lex_mode_r  = dbgtok_pkg::MODE_IDLE;
        prompt_seen = 3'd0;
        in_escape   = 1'b0;
        held_count  = 0;
        word_text   = 1'b0;
    endtask

    // A byte seen while no token is open.
    task automatic open_token(input logic [7:0] c);
        logic [3:0] kind;
        kind = punct_code(c);
        if (c == dbgtok_pkg::CH_QUOTE)
        begin
            note(dbgtok_pkg::EV_START, dbgtok_pkg::KIND_STRING, NO_CHAR);
            lex_mode_r = dbgtok_pkg::MODE_STRING;
            in_escape  = 1'b0;
        end
        else if (c == dbgtok_pkg::CH_LPAREN)
        begin
            note(dbgtok_pkg::EV_START, dbgtok_pkg::KIND_PROMPT, NO_CHAR);
            note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
            lex_mode_r  = dbgtok_pkg::MODE_PROMPT;
            prompt_seen = 3'd1;
        end
        else if (kind != dbgtok_pkg::KIND_NONE)
        begin
            note(dbgtok_pkg::EV_START, kind, NO_CHAR);
            note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
        end
        else if (c != dbgtok_pkg::CH_SPACE)
        begin
            // Leading whitespace other than a space opens a word but is not part of it.
            note(dbgtok_pkg::EV_START, dbgtok_pkg::KIND_WORD, NO_CHAR);
            lex_mode_r = dbgtok_pkg::MODE_WORD;
            held_count = 0;
            word_text  = !is_blank(c);
            if (word_text)
                note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
        end
    endtask

    task automatic lex_reply_byte(input logic [7:0] c, input logic eol);
        token_event_t e;
        int           i;
        byte_events.delete();
        case (lex_mode_r)
            dbgtok_pkg::MODE_IDLE:
                open_token(c);
            dbgtok_pkg::MODE_PROMPT:
            begin
                note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
                if (prompt_seen >= 3'd5 || c != PROMPT_TEXT[39 - 8 * int'(prompt_seen) -: 8])
                begin
                    note(dbgtok_pkg::EV_RETYPE, dbgtok_pkg::KIND_WORD, NO_CHAR);
                    lex_mode_r  = dbgtok_pkg::MODE_IDLE;
                    prompt_seen = 3'd0;
                end
                else
                begin
                    prompt_seen = prompt_seen + 3'd1;
                    if (prompt_seen == 3'd5)
                    begin
                        lex_mode_r  = dbgtok_pkg::MODE_IDLE;
                        prompt_seen = 3'd0;
                    end
                end
            end
            dbgtok_pkg::MODE_STRING:
            begin
                if (in_escape)
                begin
                    note(dbgtok_pkg::EV_CHAR, NO_KIND,
                         (c == dbgtok_pkg::CH_LOWER_N) ? dbgtok_pkg::CH_NEWLINE : c);
                    in_escape = 1'b0;
                end
                else if (c == dbgtok_pkg::CH_BSLASH)
                    in_escape = 1'b1;
                else if (c == dbgtok_pkg::CH_QUOTE)
                    lex_mode_r = dbgtok_pkg::MODE_IDLE;
                else
                    note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
            end
            default:
            begin
                if (c == dbgtok_pkg::CH_EQ || c == dbgtok_pkg::CH_COMMA ||
                    c == dbgtok_pkg::CH_LBRACE || c == dbgtok_pkg::CH_RBRACE)
                begin
                    // The delimiter closes the word and is lexed again as a token of its own.
                    held_count = 0;
                    word_text  = 1'b0;
                    lex_mode_r = dbgtok_pkg::MODE_IDLE;
                    open_token(c);
                end
                else if (is_blank(c))
                begin
                    if (word_text)
                    begin
                        if (held_count < dbgtok_pkg::HOLD_DEPTH)
                        begin
                            held_ws[held_count] = c;
                            held_count++;
                        end
                        else
                        begin
                            // A full hold gives up its oldest byte to make room.
                            note(dbgtok_pkg::EV_CHAR, NO_KIND, held_ws[0]);
                            for (i = 0; i < dbgtok_pkg::HOLD_DEPTH - 1; i++)
                                held_ws[i] = held_ws[i + 1];
                            held_ws[dbgtok_pkg::HOLD_DEPTH - 1] = c;
                        end
                    end
                end
                else
                begin
                    for (i = 0; i < held_count; i++)
                        note(dbgtok_pkg::EV_CHAR, NO_KIND, held_ws[i]);
                    held_count = 0;
                    note(dbgtok_pkg::EV_CHAR, NO_KIND, c);
                    word_text = 1'b1;
                end
            end
        endcase
        if (eol)
        begin
            note(dbgtok_pkg::EV_LINE, NO_KIND, NO_CHAR);
            clear_lexer();
        end
        for (i = 0; i < byte_events.size(); i++)
        begin
            e      = byte_events[i];
            e.last = (i == byte_events.size() - 1);
            due_q.insert(due_q.size(), e);
        end
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual)
        begin
            faults++;
            $display("%0t: %s differs, expected %0d, actual %0d", $time, name, expected,
                     actual);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            due_q.delete();
            faults = 0;
            fault_count <= 0;
            events_due  <= 0;
        end
        else
        begin
            // Results are taken before the byte of this edge is lexed: they cannot be its own.
            if (m_tvalid && m_tready)
            begin
                if (due_q.size() == 0)
                begin
                    faults++;
                    $display({"%0t: token event with none expected, expected nothing, ",
                              "actual %0d/%0d/0x%02h/%0b"},
                             $time, m_tuser[1:0], m_tuser[5:2], m_tdata, m_tlast);
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("event", int'(want.ev), int'(m_tuser[1:0]));
                    check_field("token kind", int'(want.kind), int'(m_tuser[5:2]));
                    check_field("character", int'(want.ch), int'(m_tdata));
                    check_field("last of byte", int'(want.last), int'(m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                lex_reply_byte(s_tdata, s_tlast);
            fault_count <= faults;
            events_due  <= due_q.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the tokenizer testbench: clock, reset, reply byte stimulus, receiver stalls and verdict.
module testbench;

    localparam int          RANDOM_BYTES = 430;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_OFF     = 300;
    localparam logic [95:0] PUNCT_CHARS  = "={}[],^+~@&*";
    localparam logic [63:0] BLANK_CHARS  = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h85,
                                            8'hA0};

    typedef struct packed {
        logic [7:0] c;
        logic       eol;
    } reply_byte_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [5:0] m_tuser;
    logic       m_tlast;

    int          fault_count;
    int          events_due;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          next_byte   = 0;
    int          burst;
    int          directed_bytes;
    logic        held_off    = 1'b0;
    reply_byte_t reply_q[$];
    reply_byte_t tail;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    debugger_reply_tokenizer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    token_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fault_count (fault_count),
        .events_due  (events_due)
    );

    task automatic add_byte(input logic [7:0] c, input logic eol);
        reply_byte_t b;
        b.c   = c;
        b.eol = eol;
        reply_q.insert(reply_q.size(), b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0);
    endtask

    task automatic end_line();
        tail     = reply_q.pop_back();
        tail.eol = 1'b1;
        reply_q.insert(reply_q.size(), tail);
    endtask

    task automatic add_blanks(input int count);
        int pick;
        repeat (count)
        begin
            pick = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
            add_byte(BLANK_CHARS[63 - 8 * pick -: 8], 1'b0);
        end
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0:       c = dbgtok_pkg::CH_QUOTE;
            1:       c = dbgtok_pkg::CH_BSLASH;
            2:       c = 8'($urandom_range(8'hA1, 8'hFF));
            3:       c = 8'($urandom_range(8'h30, 8'h39));
            default: c = 8'($urandom_range(8'h61, 8'h7A));
        endcase
        return c;
    endfunction

    // Words carry inner blank runs; now and then a run is long enough to overflow the hold.
    task automatic add_word();
        repeat ($urandom_range(1, 6))
        begin
            add_byte(word_char(), 1'b0);
            if ($urandom_range(0, 3) == 0)
                add_blanks(($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                         : $urandom_range(1, 3));
        end
    endtask

    task automatic add_string();
        add_byte(dbgtok_pkg::CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_byte(dbgtok_pkg::CH_BSLASH, 1'b0);
                case ($urandom_range(0, 3))
                    0:       add_byte(dbgtok_pkg::CH_QUOTE, 1'b0);
                    1:       add_byte(dbgtok_pkg::CH_BSLASH, 1'b0);
                    2:       add_byte(8'($urandom_range(0, 255)), 1'b0);
                    default: add_byte(dbgtok_pkg::CH_LOWER_N, 1'b0);
                endcase
            end
            else if ($urandom_range(0, 4) == 0)
                add_blanks(1);
            else
                add_byte(word_char() == dbgtok_pkg::CH_QUOTE ? 8'h41
                                                             : 8'($urandom_range(8'h61, 8'h7A)),
                         1'b0);
        end
        if ($urandom_range(0, 9) != 0)
            add_byte(dbgtok_pkg::CH_QUOTE, 1'b0);
    endtask

    task automatic add_prompt();
        string p;
        p = "(gdb)";
        if ($urandom_range(0, 9) < 6)
            add_text(p);
        else
        begin
            // A prompt broken off after some good bytes by an arbitrary one.
            for (int i = 0; i < $urandom_range(1, 4); i++)
                add_byte(p[i], 1'b0);
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic add_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            add_word();
        else if (pick < 45)
            add_string();
        else if (pick < 60)
            add_byte(PUNCT_CHARS[95 - 8 * $urandom_range(0, 11) -: 8], 1'b0);
        else if (pick < 70)
            add_prompt();
        else if (pick < 85)
            add_blanks($urandom_range(1, 3));
        else
            add_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic build_replies();
        // Idle space, a tab opening a word, and a word closed by '='.
        add_text(" \tab");
        add_byte(dbgtok_pkg::CH_EQ, 1'b1);
        // A string with an escaped newline and an escaped quote.
        add_text("\"a\\n\\\"");
        add_byte(dbgtok_pkg::CH_QUOTE, 1'b1);
        // A full prompt, then one that fails on its last byte.
        add_text("(gdb)");
        end_line();
        add_text("(gdb!");
        end_line();
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b1);
        directed_bytes = reply_q.size();
        while (reply_q.size() < directed_bytes + RANDOM_BYTES)
        begin
            repeat ($urandom_range(1, 10))
                add_token();
            end_line();
        end
    endtask

    task automatic send_byte(input reply_byte_t b);
        s_tvalid <= 1'b1;
        s_tdata  <= b.c;
        s_tlast  <= b.eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: spans of steady, random and sparse acceptance, and one long hold-off.
    initial
    begin
        forever
        begin
            if (!held_off && bytes_sent >= 150)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF)
                    @(posedge clk);
            end
            case ($urandom_range(0, 2))
                0:
                    repeat ($urandom_range(10, 80))
                    begin
                        m_tready <= 1'b1;
                        @(posedge clk);
                    end
                1:
                    repeat ($urandom_range(10, 80))
                    begin
                        m_tready <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                default:
                    repeat ($urandom_range(10, 80))
                    begin
                        m_tready <= ($urandom_range(0, 7) == 0);
                        @(posedge clk);
                    end
            endcase
        end
    end

    initial
    begin
        build_replies();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        while (next_byte < reply_q.size())
        begin
            burst = $urandom_range(1, 30);
            while (burst > 0 && next_byte < reply_q.size())
            begin
                send_byte(reply_q[next_byte]);
                next_byte++;
                bytes_sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12))
                    @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (events_due != 0)
            @(posedge clk);
        // A byte that gives no event may still be in flight.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dbgtok_pkg.sv
src/dbgtok_ctrl.sv
src/dbgtok_dp.sv
src/debugger_reply_tokenizer_core.sv
verif/token_stream_checker.sv
verif/testbench.sv
